// ===== sv/insulation_monitor_pwm_decoder_core_assert.svh =====
// ----------------------------------------------------------------------------
// Insulation monitor PWM decoder assertion macros
// Shared property forms for the concurrent checks of the decoder core.
// ----------------------------------------------------------------------------
`ifndef INSULATION_MONITOR_PWM_DECODER_CORE_ASSERT_SVH
`define INSULATION_MONITOR_PWM_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define IMDEC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("imdec: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define IMDEC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("imdec: next-cycle check failed");

`endif

// ===== sv/imdec_pkg.sv =====
// ----------------------------------------------------------------------------
// imdec_pkg
// Types, widths and constants shared by the PWM decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package imdec_pkg;

  localparam int WORD_W = 32;
  localparam int DUTY_W = 15;
  localparam int FREQ_W = 40;
  localparam int CODE_W = 3;

  localparam int IN_DATA_W  = 104;  // 97 field bits padded to bytes
  localparam int OUT_DATA_W = 64;   // 60 field bits padded to bytes

  // Divider: duty dividend is high * 25600, below 2^47.
  localparam int DIV_W     = 47;
  localparam int DIV_CNT_W = 6;
  localparam int DUTY_SCALE_W = 15;
  localparam logic [DUTY_SCALE_W-1:0] DUTY_SCALE = 15'd25600;
  localparam int FREQ_SHIFT = 8;
  localparam logic [DIV_CNT_W-1:0] DUTY_STEPS = 6'd47;
  localparam logic [DIV_CNT_W-1:0] FREQ_STEPS = 6'd40;

  // Status code: code = floor((clk/per + 5) / 10).
  localparam int MAX_STATUS_CODE = 5;
  localparam logic [CODE_W-1:0] UNKNOWN_CODE = CODE_W'(MAX_STATUS_CODE + 1);
  localparam int STATUS_LIMIT = (MAX_STATUS_CODE + 1) * 10 - 5;
  localparam int CODE_X_W = 8;
  localparam logic [CODE_X_W-1:0] CODE_BIAS = 8'd5;
  localparam logic [7:0] RECIP_10 = 8'd205;  // 205 / 2048 ~ 1/10, exact below 1024
  localparam int RECIP_SHIFT = 11;

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] CFG_TIMER_CLOCK = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ENABLE      = 2'd2;
  localparam logic [WORD_W-1:0] TIMEOUT_RESET = 32'd200;

  // Item kinds carried on in_tuser.
  localparam logic MODE_CAPTURE = 1'b0;
  localparam logic MODE_READ    = 1'b1;

  typedef struct packed {
    logic cap_store;
    logic chk_load;
    logic div_start_duty;
    logic div_start_freq;
    logic duty_save;
    logic freq_save;
    logic out_load;
  } imdec_cmd_t;

  typedef struct packed {
    logic chk_fail;
    logic div_busy;
  } imdec_sts_t;

endpackage

`default_nettype wire

// ===== sv/imdec_div.sv =====
// ----------------------------------------------------------------------------
// imdec_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module imdec_div
  import imdec_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [DIV_CNT_W-1:0] steps,
  input  wire logic [DIV_W-1:0]     dividend,
  input  wire logic [WORD_W-1:0]    divisor,
  output logic                      busy,
  output logic [DIV_W-1:0]          quotient
);

  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]     acc_r, acc_nxt;
  logic [WORD_W-1:0]    rem_r, rem_nxt;
  logic [WORD_W-1:0]    dsr_r, dsr_nxt;
  logic [WORD_W:0]      shifted;
  logic [WORD_W+1:0]    diff;
  logic                 qbit;

  // The dividend is left-aligned; quotient bits shift in at the bottom.
  always_comb begin
    shifted = {rem_r, acc_r[DIV_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dsr_r};
    qbit    = ~diff[WORD_W+1];
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    dsr_nxt = dsr_r;
    if (start) begin
      cnt_nxt = steps;
      acc_nxt = dividend;
      rem_nxt = '0;
      dsr_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      acc_nxt = {acc_r[DIV_W-2:0], qbit};
      rem_nxt = qbit ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy     = (cnt_r != '0);
  assign quotient = acc_r;

endmodule

`default_nettype wire

// ===== sv/imdec_ctrl.sv =====
// ----------------------------------------------------------------------------
// imdec_ctrl
// Sequencer for the PWM decoder: handshakes, checks, divisions and result.
// ----------------------------------------------------------------------------
`default_nettype none

module imdec_ctrl
  import imdec_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  input  wire logic in_tuser,
  output logic      in_tready,
  output logic      out_tvalid,
  input  wire logic out_tready,
  input  wire imdec_sts_t sts,
  output imdec_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DUTY,
    S_FREQ,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_xfer;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_tuser == MODE_READ) begin
            cmd.chk_load = 1'b1;
            state_nxt    = S_CHECK;
          end else begin
            cmd.cap_store = 1'b1;
          end
        end
      end
      S_CHECK: begin
        if (sts.chk_fail) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.div_start_duty = 1'b1;
          state_nxt          = S_DUTY;
        end
      end
      S_DUTY: begin
        if (!sts.div_busy) begin
          cmd.duty_save      = 1'b1;
          cmd.div_start_freq = 1'b1;
          state_nxt          = S_FREQ;
        end
      end
      S_FREQ: begin
        if (!sts.div_busy) begin
          cmd.freq_save = 1'b1;
          state_nxt     = S_FINISH;
        end
      end
      S_FINISH: begin
        // The output register may still hold the previous result.
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/imdec_dp.sv =====
// ----------------------------------------------------------------------------
// imdec_dp
// Datapath: configuration, capture store, read checks, divider and result.
// ----------------------------------------------------------------------------
`default_nettype none

module imdec_dp
  import imdec_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [WORD_W-1:0]     cfg_wdata,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire imdec_cmd_t            cmd,
  output imdec_sts_t                 sts,
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  logic [WORD_W-1:0] clock_hz_r, timeout_r;
  logic              enabled_r;
  logic              seen_r;
  logic [WORD_W-1:0] high_r, period_r, time_r;
  logic              chk_fail_r, ok_r;
  logic [DUTY_W-1:0] duty_r;
  logic [FREQ_W-1:0] freq_r;
  logic [OUT_DATA_W-1:0] out_r;

  logic [WORD_W-1:0] in_high, in_period, in_now, age;
  logic              in_ok, chk_fail;

  logic                 div_start, div_busy;
  logic [DIV_CNT_W-1:0] div_steps;
  logic [DIV_W-1:0]     div_dividend, div_quot, duty_prod;

  logic [WORD_W-1:0]     whole_hz;
  logic                  over_range, fault;
  logic [CODE_X_W-1:0]   code_x;
  logic [CODE_X_W+7:0]   code_prod;
  logic [CODE_W-1:0]     code;

  assign in_high   = in_tdata[WORD_W-1:0];
  assign in_period = in_tdata[2*WORD_W-1:WORD_W];
  assign in_now    = in_tdata[3*WORD_W-1:2*WORD_W];
  assign in_ok     = in_tdata[3*WORD_W];

  // Capture age uses wrapping subtraction.
  assign age      = in_now - time_r;
  assign chk_fail = !enabled_r || (clock_hz_r == '0) || !seen_r || (age > timeout_r)
                    || (period_r == '0) || (high_r > period_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= '0;
      timeout_r  <= TIMEOUT_RESET;
      enabled_r  <= 1'b0;
      seen_r     <= 1'b0;
      high_r     <= '0;
      period_r   <= '0;
      time_r     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_TIMER_CLOCK: clock_hz_r <= cfg_wdata;
          CFG_TIMEOUT:     timeout_r  <= cfg_wdata;
          CFG_ENABLE:      enabled_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (cmd.cap_store && enabled_r) begin
        seen_r   <= 1'b1;
        high_r   <= in_high;
        period_r <= in_period;
        time_r   <= in_now;
      end
    end
  end

  // Duty dividend is high * 25600; frequency dividend is clock * 256,
  // left-aligned so that only 40 steps are needed.
  assign duty_prod    = DIV_W'(high_r) * DIV_W'(DUTY_SCALE);
  assign div_start    = cmd.div_start_duty || cmd.div_start_freq;
  assign div_steps    = cmd.div_start_freq ? FREQ_STEPS : DUTY_STEPS;
  assign div_dividend = cmd.div_start_freq ? {clock_hz_r, (DIV_W - WORD_W)'(0)} : duty_prod;

  imdec_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .steps    (div_steps),
    .dividend (div_dividend),
    .divisor  (period_r),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.chk_load) begin
      chk_fail_r <= chk_fail;
      ok_r       <= in_ok;
    end
    if (cmd.duty_save) begin
      duty_r <= div_quot[DUTY_W-1:0];
    end
    if (cmd.freq_save) begin
      freq_r <= div_quot[FREQ_W-1:0];
    end
    if (cmd.out_load) begin
      out_r <= {(OUT_DATA_W - FREQ_W - DUTY_W - CODE_W - 2)'(0),
                fault ? FREQ_W'(0) : freq_r,
                fault ? DUTY_W'(0) : duty_r,
                fault ? UNKNOWN_CODE : code,
                !fault && ok_r,
                fault};
    end
  end

  // floor(clk/per) is the frequency quotient without its fraction bits.
  assign whole_hz   = freq_r[FREQ_W-1:FREQ_SHIFT];
  assign over_range = (whole_hz >= WORD_W'(STATUS_LIMIT));
  assign fault      = chk_fail_r || over_range;
  assign code_x     = whole_hz[CODE_X_W-1:0] + CODE_BIAS;
  assign code_prod  = code_x * RECIP_10;
  assign code       = code_prod[RECIP_SHIFT+CODE_W-1:RECIP_SHIFT];

  assign sts.chk_fail = chk_fail_r;
  assign sts.div_busy = div_busy;
  assign out_tdata    = out_r;

endmodule

`default_nettype wire

// ===== sv/insulation_monitor_pwm_decoder_core.sv =====
// ----------------------------------------------------------------------------
// insulation_monitor_pwm_decoder_core
// Decodes insulation monitor PWM captures into duty, frequency and status.
// ----------------------------------------------------------------------------
//  Channel  Direction  Transfer when        Contents
//  in_      slave      tvalid && tready     capture (tuser 0) or read (tuser 1)
//  out_     master     tvalid && tready     one result per read
//  cfg_     write      cfg_we               timer clock, timeout, enable
//
// A capture is stored as it is taken, and the core stays ready for the next item.
// A read is checked in S_CHECK; if it fails, S_FINISH loads its result and the
// core returns to S_IDLE. A read that passes runs the shared radix-2 divider for
// 47 steps (duty) and then 40 (frequency) in S_DUTY and S_FREQ before S_FINISH.
// Reset is synchronous and active low. A finished result waits in the output
// register; a later read holds there, with no input taken.
// ----------------------------------------------------------------------------
`default_nettype none

module insulation_monitor_pwm_decoder_core
  import imdec_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [WORD_W-1:0]     cfg_wdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // high_ticks[31:0], period_count[63:32], now_ms[95:64], ok_line[96]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // mode[0]
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // fault[0], ok_status[1], stat_code[4:2], duty_q8[19:5], freq_q8[59:20]
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  imdec_cmd_t cmd;
  imdec_sts_t sts;
  logic       cap_xfer;

  imdec_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  imdec_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

  assign cap_xfer = in_tvalid && in_tready && (in_tuser == MODE_CAPTURE);

`include "insulation_monitor_pwm_decoder_core_assert.svh"

  // A failed read carries no measurement.
  `IMDEC_ASSERT_SAME(a_fault_zeroes, out_tvalid && out_tdata[0], out_tdata[59:5] == '0 && !out_tdata[1])
  // A good read never reports a code above the top value.
  `IMDEC_ASSERT_SAME(a_code_range, out_tvalid && !out_tdata[0], out_tdata[4:2] <= CODE_W'(MAX_STATUS_CODE))
  // A capture transfer never produces a result.
  `IMDEC_ASSERT_NEXT(a_capture_silent, cap_xfer && !out_tvalid, !out_tvalid)
  // The divider is idle whenever new input is taken.
  `IMDEC_ASSERT_SAME(a_div_idle, in_tready, !sts.div_busy)

endmodule

`default_nettype wire

// ===== dv/tb_insulation_monitor_pwm_decoder_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_insulation_monitor_pwm_decoder_core
// Drives capture and read transfers into the PWM decoder core and checks
// every read result, field by field, against a predictor of the decoder.
// The predictor runs alongside a scoreboard. The stimulus starts with
// directed cases and then runs randomized phases under several register
// settings, with random idling on both stream sides.
// ----------------------------------------------------------------------------

module tb_insulation_monitor_pwm_decoder_core;
  import imdec_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned IDLE_PCT      = 23;

  typedef struct packed {
    logic              fault;
    logic              ok_status;
    logic [CODE_W-1:0] stat_code;
    logic [DUTY_W-1:0] duty_q8;
    logic [FREQ_W-1:0] freq_q8;
  } decode_result_t;

  class pwm_decode_scoreboard;
    logic [WORD_W-1:0] clock_hz;
    logic [WORD_W-1:0] timeout_ticks;
    logic              enabled;
    logic              seen;
    logic [WORD_W-1:0] high_q;
    logic [WORD_W-1:0] period_q;
    logic [WORD_W-1:0] stamp_q;
    decode_result_t    expected_q[$];
    int unsigned       errors;

    function new();
      clock_hz      = '0;
      timeout_ticks = 32'd200;
      enabled       = 1'b0;
      seen          = 1'b0;
      high_q        = '0;
      period_q      = '0;
      stamp_q       = '0;
      errors        = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [WORD_W-1:0] val);
      case (idx)
        CFG_TIMER_CLOCK: clock_hz = val;
        CFG_TIMEOUT:     timeout_ticks = val;
        CFG_ENABLE:      enabled = val[0];
        default: ;
      endcase
    endfunction

    function decode_result_t decode_read(logic [WORD_W-1:0] now, logic ok_line);
      decode_result_t r;
      logic [WORD_W-1:0] age;
      logic [63:0] per64;
      logic [63:0] clk64;
      logic [63:0] code64;
      r = '{fault: 1'b1, ok_status: 1'b0, stat_code: UNKNOWN_CODE,
            duty_q8: '0, freq_q8: '0};
      age   = now - stamp_q;
      per64 = {32'd0, period_q};
      clk64 = {32'd0, clock_hz};
      if (!enabled || clock_hz == 0 || !seen || age > timeout_ticks ||
          period_q == 0 || high_q > period_q)
        return r;
      // Round to nearest: floor((f + 5) / 10) with f = clock / period.
      code64 = (clk64 + 64'd5 * per64) / (64'd10 * per64);
      if (code64 > MAX_STATUS_CODE)
        return r;
      r.fault     = 1'b0;
      r.ok_status = ok_line;
      r.stat_code = CODE_W'(code64);
      r.duty_q8   = DUTY_W'(({32'd0, high_q} * 64'd25600) / per64);
      r.freq_q8   = FREQ_W'((clk64 << 8) / per64);
      return r;
    endfunction

    function void note_item(logic mode, logic [IN_DATA_W-1:0] data);
      if (mode == MODE_CAPTURE) begin
        if (enabled) begin
          high_q   = data[31:0];
          period_q = data[63:32];
          stamp_q  = data[95:64];
          seen     = 1'b1;
        end
      end else begin
        expected_q.push_back(decode_read(data[95:64], data[96]));
      end
    endfunction

    function void compare_field(string name, longint unsigned exp, longint unsigned act);
      if (exp != act) begin
        $error("%s: expected %0h, got %0h", name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      decode_result_t exp;
      if (expected_q.size() == 0) begin
        $error("result transfer with no read outstanding: %0h", data);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      compare_field("fault", exp.fault, data[0]);
      compare_field("ok_status", exp.ok_status, data[1]);
      compare_field("stat_code", exp.stat_code, data[4:2]);
      compare_field("duty_q8", exp.duty_q8, data[19:5]);
      compare_field("freq_q8", exp.freq_q8, data[59:20]);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [WORD_W-1:0]     cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // high_ticks[31:0], period_count[63:32], now_ms[95:64], ok_line[96]
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  // mode[0]
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // fault[0], ok_status[1], stat_code[4:2], duty_q8[19:5], freq_q8[59:20]
  logic [OUT_DATA_W-1:0] out_tdata;

  pwm_decode_scoreboard sb = new();

  bit                calm = 1'b0;
  int unsigned       stall_cycles = 0;
  logic [WORD_W-1:0] cur_clock = '0;
  logic [WORD_W-1:0] cur_timeout = 32'd200;
  logic              cur_enable = 1'b0;
  logic [WORD_W-1:0] tick = '0;
  logic [WORD_W-1:0] cap_stamp = '0;

  insulation_monitor_pwm_decoder_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Result checking and the stall watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("insulation_monitor_pwm_decoder_core test failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic push_item(input logic mode, input logic [WORD_W-1:0] high_cnt,
                           input logic [WORD_W-1:0] period_cnt,
                           input logic [WORD_W-1:0] now, input logic ok_line);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {7'd0, ok_line, now, period_cnt, high_cnt};
    do @(posedge clk); while (!in_tready);
    sb.note_item(mode, {7'd0, ok_line, now, period_cnt, high_cnt});
  endtask

  // Stop sending and let every outstanding read come back.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [WORD_W-1:0] clock_hz,
                           input logic [WORD_W-1:0] timeout, input logic enable);
    logic [CFG_ADDR_W-1:0] idx [4];
    logic [WORD_W-1:0]     val [4];
    idx = '{CFG_TIMER_CLOCK, CFG_TIMEOUT, CFG_ENABLE, CFG_UNUSED};
    val = '{clock_hz, timeout, {31'd0, enable}, $urandom()};
    settle();
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= idx[i];
      cfg_wdata <= val[i];
      sb.write_reg(idx[i], val[i]);
      @(posedge clk);
    end
    cfg_we      <= 1'b0;
    cur_clock   = clock_hz;
    cur_timeout = timeout;
    cur_enable  = enable;
  endtask

  task automatic send_capture();
    logic [WORD_W-1:0] per;
    logic [WORD_W-1:0] hi;
    per = cur_clock / $urandom_range(60, 1);
    // A clock slower than the divisor gives a period of zero; a random odd period is used instead.
    if (per == 0)
      per = $urandom() | 32'd1;
    if ($urandom_range(19) == 0)
      per = '0;
    case ($urandom_range(19))
      0: hi = per;
      1: hi = per + 1;
      2: hi = $urandom();
      default: hi = $urandom_range(per, 0);
    endcase
    tick = tick + $urandom_range(40, 1);
    push_item(MODE_CAPTURE, hi, per, tick, 1'($urandom_range(1, 0)));
    if (cur_enable)
      cap_stamp = tick;
  endtask

  task automatic send_read();
    logic [WORD_W-1:0] age;
    case ($urandom_range(9))
      0: age = cur_timeout;
      1: age = cur_timeout + 1;
      2: age = $urandom();
      default: age = (cur_timeout < 64) ? $urandom_range(cur_timeout, 0)
                                        : $urandom_range(63, 0);
    endcase
    push_item(MODE_READ, $urandom(), $urandom(), cap_stamp + age,
              1'($urandom_range(1, 0)));
  endtask

  task automatic run_random(input int unsigned budget);
    int unsigned sent;
    int unsigned reads;
    bit paused;
    logic mode;
    sent   = 0;
    paused = 1'b0;
    while (sent < budget) begin
      if (!paused && sent >= budget / 2) begin
        settle();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 75) begin
        send_capture();
        reads = $urandom_range(3, 1);
        repeat (reads) send_read();
        sent += reads + (cur_enable ? 1 : 0);
      end else begin
        mode = 1'($urandom_range(1, 0));
        push_item(mode, $urandom(), $urandom(), $urandom(), 1'($urandom_range(1, 0)));
        if (mode == MODE_READ || cur_enable)
          sent++;
      end
    end
  endtask

  initial begin
    tick = $urandom();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: capture is off, so reads fail and captures are dropped.
    push_item(MODE_READ, '0, '0, 32'd0, 1'b1);
    push_item(MODE_CAPTURE, 32'd5, 32'd10, 32'd0, 1'b0);

    configure(32'd1000, 32'd200, 1'b1);
    push_item(MODE_READ, '0, '0, 32'd0, 1'b1);
    push_item(MODE_CAPTURE, 32'd0, 32'd25, 32'd100, 1'b0);
    push_item(MODE_READ, '0, '0, 32'd100, 1'b1);
    push_item(MODE_READ, '0, '0, 32'd300, 1'b0);
    push_item(MODE_READ, '0, '0, 32'd301, 1'b1);
    // The time stamp wraps between capture and read.
    push_item(MODE_CAPTURE, 32'd20, 32'd20, 32'hFFFF_FFF0, 1'b0);
    push_item(MODE_READ, '0, '0, 32'h0000_0050, 1'b1);
    push_item(MODE_CAPTURE, 32'd21, 32'd20, 32'd1000, 1'b0);
    push_item(MODE_READ, '0, '0, 32'd1000, 1'b1);
    push_item(MODE_CAPTURE, 32'd0, 32'd0, 32'd1000, 1'b0);
    push_item(MODE_READ, '0, '0, 32'd1000, 1'b1);
    // About 55.6 Hz rounds above the top status value.
    push_item(MODE_CAPTURE, 32'd1, 32'd18, 32'd1000, 1'b0);
    push_item(MODE_READ, '0, '0, 32'd1000, 1'b1);
    push_item(MODE_CAPTURE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b1);
    push_item(MODE_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b1);

    configure(32'd0, 32'd0, 1'b1);
    push_item(MODE_READ, '0, '0, 32'd0, 1'b1);

    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    push_item(MODE_CAPTURE, 32'd12345, 32'd85899345, 32'd0, 1'b0);
    push_item(MODE_READ, '0, '0, 32'hFFFF_FFFF, 1'b1);

    configure(32'd1000, 32'd200, 1'b0);
    push_item(MODE_READ, '0, '0, 32'd5, 1'b1);
    push_item(MODE_CAPTURE, 32'd1, 32'd10, 32'd5, 1'b0);

    configure(32'd1000, 32'd200, 1'b1);
    push_item(MODE_READ, '0, '0, 32'd5, 1'b1);

    // Randomized phases; the first runs with no idling on either side.
    configure(32'd1_000_000, 32'd200, 1'b1);
    calm = 1'b1;
    run_random(400);
    settle();
    calm = 1'b0;
    configure(32'd1, 32'd0, 1'b1);
    run_random(250);
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    run_random(250);
    configure($urandom(), $urandom_range(1000, 0), 1'b1);
    run_random(300);
    configure($urandom(), $urandom(), 1'b0);
    run_random(100);
    configure(32'd50_000, 32'd200, 1'b1);
    run_random(350);

    settle();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("insulation_monitor_pwm_decoder_core test passed");
    else
      $display("insulation_monitor_pwm_decoder_core test failed");
    $finish;
  end

endmodule
